// ===== rtl/keyword_token_lexer_defines.svh =====
// Assertion macros for the lexer RTL.
`ifndef KEYWORD_TOKEN_LEXER_DEFINES_SVH
`define KEYWORD_TOKEN_LEXER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define KTL_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ktl assertion failed");

// Same-cycle implication.
`define KTL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ktl assertion failed");

// Next-cycle implication.
`define KTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ktl assertion failed");

`endif

// ===== rtl/ktl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ktl_pkg;

    localparam int KEEP_CHARS = 7;
    localparam int KW_COUNT   = 12;
    localparam int MAX_LEN    = 8;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_AT    = "@";
    localparam logic [7:0] CH_DOT   = ".";
    localparam logic [7:0] CH_OPEN  = "(";
    localparam logic [7:0] CH_CLOSE = ")";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_SPACE = " ";

    // byte 0 is the first character of the word
    typedef logic [KEEP_CHARS-1:0][7:0] t_chars;

    typedef enum logic [4:0] {
        KIND_WORD_CHAR = 5'd0,
        KIND_SELECT    = 5'd1,
        KIND_CREATE    = 5'd2,
        KIND_TABLE     = 5'd3,
        KIND_INSERT    = 5'd4,
        KIND_INTO      = 5'd5,
        KIND_SHOW      = 5'd6,
        KIND_ENTRIES   = 5'd7,
        KIND_FROM      = 5'd8,
        KIND_DROP      = 5'd9,
        KIND_INT       = 5'd10,
        KIND_STRING    = 5'd11,
        KIND_BOOL      = 5'd12,
        KIND_IDENT     = 5'd13,
        KIND_OPEN      = 5'd14,
        KIND_CLOSE     = 5'd15,
        KIND_COMMA     = 5'd16,
        KIND_ERROR     = 5'd17
    } t_kind;

    typedef struct packed {
        t_chars     recent;
        logic [3:0] len;
        logic       in_word;
        logic       halted;
    } t_lex_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_value;
    } t_token;

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_result;

    typedef struct packed {
        t_token     first;
        t_token     second;
        logic [1:0] count;
        t_lex_state next_state;
    } t_step;

    // upper-case keywords, zero padded; entry k gives kind k+1
    localparam t_chars KW_UPPER [KW_COUNT] = '{
        {8'h00, "T", "C", "E", "L", "E", "S"},
        {8'h00, "E", "T", "A", "E", "R", "C"},
        {8'h00, 8'h00, "E", "L", "B", "A", "T"},
        {8'h00, "T", "R", "E", "S", "N", "I"},
        {8'h00, 8'h00, 8'h00, "O", "T", "N", "I"},
        {8'h00, 8'h00, 8'h00, "W", "O", "H", "S"},
        {"S", "E", "I", "R", "T", "N", "E"},
        {8'h00, 8'h00, 8'h00, "M", "O", "R", "F"},
        {8'h00, 8'h00, 8'h00, "P", "O", "R", "D"},
        {8'h00, 8'h00, 8'h00, 8'h00, "T", "N", "I"},
        {8'h00, "G", "N", "I", "R", "T", "S"},
        {8'h00, 8'h00, 8'h00, "L", "O", "O", "B"}
    };

    // keywords hold letters only, so lower case is bit 5 set on each used byte
    function automatic t_chars to_lower(input t_chars s);
        t_chars r;
        for (int i = 0; i < KEEP_CHARS; i++) begin
            r[i] = (s[i] != 8'h00) ? (s[i] | 8'h20) : 8'h00;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ktl_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ktl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface ktl_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] kind;
    logic [7:0] char_value;
    logic       last_of_step;

    modport source (output valid, output kind, output char_value, output last_of_step,
                    input ready);
    modport sink   (input valid, input kind, input char_value, input last_of_step,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ktl_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktl_classify (
    input  wire ktl_pkg::t_lex_state i_state,
    input  wire logic [7:0]          i_ch,
    input  wire logic                i_eoi,
    output ktl_pkg::t_step           o_step
);

    ktl_pkg::t_kind     w_word_kind;
    ktl_pkg::t_token    w_tok;
    logic               w_has_tok;
    logic               w_alnum;
    logic               w_wordc;
    logic               w_err;

    always_comb begin
        w_alnum = ((i_ch >= "0") && (i_ch <= "9")) || ((i_ch >= "A") && (i_ch <= "Z")) ||
                  ((i_ch >= "a") && (i_ch <= "z"));
        w_wordc = w_alnum || (i_ch == ktl_pkg::CH_DASH) || (i_ch == ktl_pkg::CH_UNDER) ||
                  (i_ch == ktl_pkg::CH_AT) || (i_ch == ktl_pkg::CH_DOT);
    end

    // bytes past the word length are always zero, so a padded compare is exact
    always_comb begin
        w_word_kind = ktl_pkg::KIND_IDENT;
        for (int k = 0; k < ktl_pkg::KW_COUNT; k++) begin
            if ((i_state.len < 4'(ktl_pkg::MAX_LEN)) &&
                ((i_state.recent == ktl_pkg::KW_UPPER[k]) ||
                 (i_state.recent == ktl_pkg::to_lower(ktl_pkg::KW_UPPER[k])))) begin
                w_word_kind = ktl_pkg::t_kind'(5'(k + 1));
            end
        end
    end

    // token for a character that does not continue a word
    always_comb begin
        w_tok     = '{kind: ktl_pkg::KIND_WORD_CHAR, char_value: 8'h00};
        w_has_tok = 1'b1;
        w_err     = 1'b0;
        priority if (w_alnum) begin
            w_tok.char_value = i_ch;
        end else if (i_ch == ktl_pkg::CH_OPEN) begin
            w_tok.kind = ktl_pkg::KIND_OPEN;
        end else if (i_ch == ktl_pkg::CH_CLOSE) begin
            w_tok.kind = ktl_pkg::KIND_CLOSE;
        end else if (i_ch == ktl_pkg::CH_COMMA) begin
            w_tok.kind = ktl_pkg::KIND_COMMA;
        end else if (i_ch == ktl_pkg::CH_SPACE) begin
            w_has_tok = 1'b0;
        end else begin
            w_tok.kind = ktl_pkg::KIND_ERROR;
            w_err      = 1'b1;
        end
    end

    always_comb begin
        o_step            = '0;
        o_step.next_state = i_state;
        priority if (i_eoi) begin
            o_step.first.kind = w_word_kind;
            o_step.count      = {1'b0, i_state.in_word && !i_state.halted};
            o_step.next_state = '0;
        end else if (i_state.halted) begin
            o_step.count = 2'd0;
        end else if (i_state.in_word && w_wordc) begin
            o_step.first.char_value = i_ch;
            o_step.count            = 2'd1;
            for (int i = 0; i < ktl_pkg::KEEP_CHARS; i++) begin
                if (i_state.len == 4'(i)) begin
                    o_step.next_state.recent[i] = i_ch;
                end
            end
            if (i_state.len < 4'(ktl_pkg::MAX_LEN)) begin
                o_step.next_state.len = i_state.len + 4'd1;
            end
        end else begin
            // word kind first, then the character's own token
            if (i_state.in_word) begin
                o_step.first.kind = w_word_kind;
                o_step.second     = w_tok;
            end else begin
                o_step.first = w_tok;
            end
            o_step.count      = 2'({1'b0, i_state.in_word}) + 2'({1'b0, w_has_tok});
            o_step.next_state = '0;
            if (w_alnum) begin
                o_step.next_state.in_word   = 1'b1;
                o_step.next_state.len       = 4'd1;
                o_step.next_state.recent[0] = i_ch;
            end
            o_step.next_state.halted = w_err;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ktl_result_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ktl_result_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [1:0]         i_push_count,
    input  wire ktl_pkg::t_token    i_first,
    input  wire ktl_pkg::t_token    i_second,
    input  wire logic               i_pop,
    output logic                    o_room,
    output logic                    o_valid,
    output ktl_pkg::t_result        o_result
);

    ktl_pkg::t_result               r_mem [ktl_pkg::FIFO_DEPTH];
    logic [ktl_pkg::PTR_W-1:0]      r_wr;
    logic [ktl_pkg::PTR_W-1:0]      r_rd;
    logic [ktl_pkg::PTR_W:0]        r_count;
    logic [ktl_pkg::PTR_W-1:0]      n_wr;
    logic [ktl_pkg::PTR_W-1:0]      n_rd;
    logic [ktl_pkg::PTR_W:0]        n_count;
    logic                           w_pop;

    assign o_valid  = (r_count != '0);
    assign o_result = r_mem[r_rd];
    // room for a full two-result step
    assign o_room   = (r_count <= (ktl_pkg::PTR_W + 1)'(ktl_pkg::FIFO_DEPTH - 2));
    assign w_pop    = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr + ktl_pkg::PTR_W'(i_push_count);
        n_rd    = r_rd + ktl_pkg::PTR_W'(w_pop);
        n_count = r_count + (ktl_pkg::PTR_W + 1)'(i_push_count)
                - (ktl_pkg::PTR_W + 1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= '{tok: i_first, last: (i_push_count == 2'd1)};
        end
        if (i_push_count == 2'd2) begin
            r_mem[r_wr + ktl_pkg::PTR_W'(1)] <= '{tok: i_second, last: 1'b1};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/keyword_token_lexer.sv =====
// An accepted input beat is held in the input stage, then its results enter the result
// queue. Throughput: one input beat per cycle while results drain at one beat per cycle
// and the queue has room for both results; a beat that ends a word yields two results,
// so the single result port sets the pace. Reset (i_rst_n low, synchronous): word state,
// halt flag, input stage and result queue are cleared; no beats are pending afterwards.
`timescale 1ns / 1ps
`default_nettype none

`include "keyword_token_lexer_defines.svh"

module keyword_token_lexer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ktl_in_if.sink      i_in,
    ktl_out_if.source   o_out
);

    // input register stage
    logic               r_in_valid;
    logic [7:0]         r_in_ch;
    logic               r_in_eoi;

    // lexer state: first seven chars, saturating length, word-open and halt flags
    ktl_pkg::t_lex_state r_state;

    ktl_pkg::t_step     w_step;
    ktl_pkg::t_result   w_head;
    logic               w_room;
    logic               w_adv;

    // an item is processed only when the queue can take both of its results
    assign w_adv      = r_in_valid && w_room;
    assign i_in.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_ch  <= i_in.ch;
            r_in_eoi <= i_in.end_of_input;
        end
    end

    // word match, token selection and next-state logic
    ktl_classify u_classify (
        .i_state (r_state),
        .i_ch    (r_in_ch),
        .i_eoi   (r_in_eoi),
        .o_step  (w_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_adv) begin
            r_state <= w_step.next_state;
        end
    end

    // result queue decouples the output beat from the input side
    ktl_result_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (w_adv ? w_step.count : 2'd0),
        .i_first      (w_step.first),
        .i_second     (w_step.second),
        .i_pop        (o_out.ready),
        .o_room       (w_room),
        .o_valid      (o_out.valid),
        .o_result     (w_head)
    );

    assign o_out.kind         = w_head.tok.kind;
    assign o_out.char_value   = w_head.tok.char_value;
    assign o_out.last_of_step = w_head.last;

    // a halt always closes the open word
    `KTL_ASSERT_IMPL(a_halt_no_word, i_clk, i_rst_n, r_state.halted, !r_state.in_word)
    // length is nonzero exactly while a word is open
    `KTL_ASSERT_ALWAYS(a_len_word, i_clk, i_rst_n, r_state.in_word == (r_state.len != 4'd0))
    // end of input leaves the state cleared
    `KTL_ASSERT_NEXT(a_eoi_clear, i_clk, i_rst_n, w_adv && r_in_eoi,
        !r_state.in_word && !r_state.halted && (r_state.len == 4'd0))
    // the length never goes past its saturation point
    `KTL_ASSERT_ALWAYS(a_len_sat, i_clk, i_rst_n, r_state.len <= 4'(ktl_pkg::MAX_LEN))

endmodule

`default_nettype wire

// ===== test/ktl_token_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the lexer, predicts its tokens and compares them in order.
module ktl_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ktl_in_if           i_in_bus,
    ktl_out_if          i_out_bus,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    typedef struct {
        ktl_pkg::t_kind kind;
        logic [7:0]     char_value;
        logic           last;
    } t_expected;

    string keyword_names [ktl_pkg::KW_COUNT] = '{
        "SELECT", "CREATE", "TABLE", "INSERT", "INTO", "SHOW",
        "ENTRIES", "FROM", "DROP", "INT", "STRING", "BOOL"
    };

    t_expected  expected_tokens [$];

    // predicted lexer state
    logic [7:0] word_chars [ktl_pkg::KEEP_CHARS];
    logic [3:0] word_len;
    logic       in_word;
    logic       halted;

    function automatic bit is_alnum(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit is_word_byte(logic [7:0] c);
        return is_alnum(c) || c == ktl_pkg::CH_DASH || c == ktl_pkg::CH_UNDER ||
               c == ktl_pkg::CH_AT || c == ktl_pkg::CH_DOT;
    endfunction

    function automatic void clear_word();
        foreach (word_chars[i]) word_chars[i] = 8'h00;
        word_len = '0;
        in_word  = 1'b0;
    endfunction

    function automatic bit spelled_as(string w);
        if (w.len() != int'(word_len)) return 1'b0;
        for (int i = 0; i < w.len(); i++) begin
            if (word_chars[i] != w[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic ktl_pkg::t_kind word_kind();
        if (word_len > ktl_pkg::KEEP_CHARS) return ktl_pkg::KIND_IDENT;
        for (int k = 0; k < ktl_pkg::KW_COUNT; k++) begin
            if (spelled_as(keyword_names[k]) || spelled_as(keyword_names[k].tolower()))
                return ktl_pkg::t_kind'(k + 1);
        end
        return ktl_pkg::KIND_IDENT;
    endfunction

    // append one predicted token at the tail of the queue
    function automatic void add_expected(ktl_pkg::t_kind kind, logic [7:0] cv);
        t_expected t;
        t.kind       = kind;
        t.char_value = cv;
        t.last       = 1'b0;
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic void lex_beat(logic [7:0] c, logic eoi);
        int first_new;
        first_new = expected_tokens.size();
        if (eoi) begin
            if (in_word && !halted) add_expected(word_kind(), 8'h00);
            clear_word();
            halted = 1'b0;
        end else if (!halted) begin
            if (in_word && is_word_byte(c)) begin
                if (word_len < ktl_pkg::KEEP_CHARS) word_chars[word_len] = c;
                if (word_len < ktl_pkg::MAX_LEN) word_len++;
                add_expected(ktl_pkg::KIND_WORD_CHAR, c);
            end else begin
                // a non-word byte closes the pending word first
                if (in_word) begin
                    add_expected(word_kind(), 8'h00);
                    clear_word();
                end
                if (is_alnum(c)) begin
                    in_word       = 1'b1;
                    word_chars[0] = c;
                    word_len      = 4'd1;
                    add_expected(ktl_pkg::KIND_WORD_CHAR, c);
                end else if (c == ktl_pkg::CH_OPEN) begin
                    add_expected(ktl_pkg::KIND_OPEN, 8'h00);
                end else if (c == ktl_pkg::CH_CLOSE) begin
                    add_expected(ktl_pkg::KIND_CLOSE, 8'h00);
                end else if (c == ktl_pkg::CH_COMMA) begin
                    add_expected(ktl_pkg::KIND_COMMA, 8'h00);
                end else if (c != ktl_pkg::CH_SPACE) begin
                    add_expected(ktl_pkg::KIND_ERROR, 8'h00);
                    halted = 1'b1;
                end
            end
        end
        if (expected_tokens.size() > first_new)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns: token mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_expected want;
        if (!i_rst_n) begin
            expected_tokens.delete();
            clear_word();
            halted = 1'b0;
        end else begin
            if (i_in_bus.valid && i_in_bus.ready)
                lex_beat(i_in_bus.ch, i_in_bus.end_of_input);
            if (i_out_bus.valid && i_out_bus.ready) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d char %02h last %0b",
                        i_out_bus.kind, i_out_bus.char_value, i_out_bus.last_of_step));
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_out_bus.kind !== want.kind ||
                        i_out_bus.char_value !== want.char_value ||
                        i_out_bus.last_of_step !== want.last) begin
                        report_mismatch($sformatf(
                            "got kind %0d char %02h last %0b, want kind %0d char %02h last %0b",
                            i_out_bus.kind, i_out_bus.char_value, i_out_bus.last_of_step,
                            want.kind, want.char_value, want.last));
                    end
                end
            end
        end
        o_pending <= expected_tokens.size();
    end

endmodule

// ===== test/tb_keyword_token_lexer.sv =====
`timescale 1ns / 1ps

// Top of the lexer bench: clock, reset, character stream, result back-pressure,
// watchdog and verdict. Prediction and comparison live in ktl_token_checker.
module tb_keyword_token_lexer;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
    localparam int TAIL_CYCLES    = 8;     // quiet time after the last token drains
    localparam int ITEM_TARGET    = 750;   // random beats over all three phases

    logic        i_clk = 1'b0;
    logic        i_rst_n;

    ktl_in_if    in_bus ();
    ktl_out_if   out_bus ();

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned quiet_cycles;

    // percent chance per cycle that each side holds off
    int          send_idle_pct;
    int          recv_idle_pct;
    int          beats_sent;

    string keyword_names [ktl_pkg::KW_COUNT] = '{
        "SELECT", "CREATE", "TABLE", "INSERT", "INTO", "SHOW",
        "ENTRIES", "FROM", "DROP", "INT", "STRING", "BOOL"
    };

    keyword_token_lexer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    ktl_token_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_bus     (in_bus),
        .i_out_bus    (out_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #5 i_clk = ~i_clk;

    // Result side back-pressure: ready rolls fresh every cycle.
    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung block shows up as a long run with no beat anywhere.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One input beat. Random gaps go in front of the beat; valid then stays
    // high until the edge that sees ready, so only one update per time step.
    task automatic send_beat(input logic [7:0] c, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.ch           <= c;
        in_bus.end_of_input <= eoi;
        @(posedge i_clk);
        while (in_bus.ready !== 1'b1) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    endtask

    // end of input; the byte rides along with random content since it is ignored
    task automatic send_end();
        send_beat(8'($urandom_range(255)), 1'b1);
    endtask

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(61);
        if (r < 10) return 8'("0" + r);
        if (r < 36) return 8'("A" + r - 10);
        return 8'("a" + r - 36);
    endfunction

    // any byte that may continue a word
    function automatic logic [7:0] rand_word_byte();
        case ($urandom_range(7))
            0:       return ktl_pkg::CH_DASH;
            1:       return ktl_pkg::CH_UNDER;
            2:       return ktl_pkg::CH_AT;
            3:       return ktl_pkg::CH_DOT;
            default: return rand_alnum();
        endcase
    endfunction

    function automatic string rand_ident(input int len);
        string w;
        w = $sformatf("%c", rand_alnum());
        for (int i = 1; i < len; i++) w = $sformatf("%s%c", w, rand_word_byte());
        return w;
    endfunction

    // One token of command text: keywords in every spelling, near misses,
    // identifiers of random length (the odd one well past the kept length)
    // and punctuation.
    function automatic string pick_token();
        int    roll;
        string w;
        roll = $urandom_range(99);
        w    = keyword_names[$urandom_range(ktl_pkg::KW_COUNT - 1)];
        if (roll < 40) begin
            case ($urandom_range(9))
                0: begin
                    // mixed case is an identifier unless every flip lands the same way
                    for (int i = 0; i < w.len(); i++)
                        if ($urandom_range(1)) w[i] = w[i] ^ 8'h20;
                end
                1, 2, 3, 4: w = w.tolower();
                default: ;
            endcase
        end else if (roll < 52) begin
            // near miss: one character short or one too many
            if ($urandom_range(1)) w = w.substr(0, w.len() - 2);
            else                   w = $sformatf("%s%c", w, rand_word_byte());
            if ($urandom_range(1)) w = w.tolower();
        end else if (roll < 72) begin
            w = rand_ident(($urandom_range(9) == 0) ? $urandom_range(8, 14)
                                                    : $urandom_range(1, 7));
        end else begin
            case ($urandom_range(2))
                0:       w = "(";
                1:       w = ")";
                default: w = ",";
            endcase
        end
        return w;
    endfunction

    // A statement is a run of tokens closed by end of input. Some carry a
    // random byte part way through and end right after it: most such bytes
    // are errors, the rest just cut the statement short.
    task automatic send_statement();
        int n_tokens;
        int noise_at;
        n_tokens = $urandom_range(1, 8);
        noise_at = ($urandom_range(99) < 12) ? $urandom_range(0, n_tokens - 1) : -1;
        for (int t = 0; t < n_tokens; t++) begin
            if (t == noise_at) begin
                send_beat(8'($urandom_range(255)), 1'b0);
                break;
            end
            send_text(pick_token());
            // adjacent words merge into one, which is fine too
            case ($urandom_range(3))
                0:       send_text("  ");
                1, 2:    send_text(" ");
                default: ;
            endcase
        end
        send_end();
    endtask

    initial begin
        in_bus.valid        <= 1'b0;
        in_bus.ch           <= 8'h00;
        in_bus.end_of_input <= 1'b0;
        i_rst_n             <= 1'b0;
        beats_sent    = 0;
        send_idle_pct = 7;
        recv_idle_pct = 49;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opener.
        send_text("SELECT,(");     // keyword closed by a comma, then an open paren
        send_text("Z0-_@.9q)");    // eight-char word with every joiner -> identifier
        send_end();                // end of input with nothing pending
        send_text("x");
        send_beat(8'hFF, 1'b0);    // high byte ends the word and raises an error
        send_text("a");            // halted: dropped
        send_beat(8'h00, 1'b0);    // halted: dropped
        send_end();                // halted end of input: silent, clears state
        send_beat(8'h00, 1'b0);    // NUL from a clean state is an error
        send_end();
        send_text("drop");
        send_end();                // flushes the pending keyword

        // Random statements in three back-pressure phases.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 7;  recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            beats_sent = 0;
            while (beats_sent < ITEM_TARGET / 3) send_statement();
        end
        in_bus.valid <= 1'b0;

        // let the checker's count catch up with the last beat, then drain
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== keyword_token_lexer.f =====
+incdir+rtl
rtl/ktl_pkg.sv
rtl/ktl_if.sv
rtl/ktl_classify.sv
rtl/ktl_result_fifo.sv
rtl/keyword_token_lexer.sv
test/ktl_token_checker.sv
test/tb_keyword_token_lexer.sv
